FILE: rtl/rhcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_pkg
// Shared types and constants of the rolling-hash chunk boundary block.
// ----------------------------------------------------------------------------
package rhcb_pkg;

	localparam int BYTE_W    = 8;
	localparam int RES_POS_W = 32;
	localparam int HASH_W    = 64;
	localparam int MLOG_W    = 5;
	localparam int TARGET_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_VALUE = 2'd1;

	localparam logic [MLOG_W-1:0]   MLOG_RESET   = 5'd8;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd0;

	// output queue
	localparam int OQ_DEPTH = 16;
	localparam int OQ_AW    = 4;
	localparam int OQ_CW    = 5;
	localparam int MAX_RES  = 3;

	// per-item control decided at acceptance
	typedef struct packed {
		logic                 first;    // position 0 of the buffer
		logic                 fin;      // last byte of the buffer
		logic                 elig;     // position far enough in for a hash test
		logic [RES_POS_W-1:0] pos_hash; // boundary reported on a hash hit
		logic [RES_POS_W-1:0] len;      // buffer length, used on the last byte
	} item_info_t;

	typedef struct packed {
		logic [RES_POS_W-1:0] pos;
		logic                 last;
	} res_t;

	// up to three results of one item, compacted from index 0
	typedef struct packed {
		logic [1:0]           n;
		res_t [MAX_RES-1:0]   res;
	} push_t;

	// 3^e modulo 2^64, elaboration only
	function automatic logic [HASH_W-1:0] pow3(input int e);
		logic [HASH_W-1:0] r;
		r = 64'd1;
		for (int k = 0; k < e; k++) begin
			r = r * 64'd3;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rhcb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rhcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and a write at one address return the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rhcb_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_hash
// Rolling hash update and boundary test; builds the results of each item.
// ----------------------------------------------------------------------------
module rhcb_hash #(
	parameter int WINDOW = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire logic [rhcb_pkg::BYTE_W-1:0]   byte_s1,
	input  wire logic [rhcb_pkg::BYTE_W-1:0]   old_s1,
	input  wire logic                          old_ok_s1,
	input  wire rhcb_pkg::item_info_t          info_s1,
	input  wire logic [rhcb_pkg::MLOG_W-1:0]   modulus_log2,
	input  wire logic [rhcb_pkg::TARGET_W-1:0] target_value,
	output rhcb_pkg::push_t                    push
);
	import rhcb_pkg::*;

	localparam logic [HASH_W-1:0] OUT_WEIGHT = pow3(WINDOW + 1);

	logic [HASH_W-1:0] old_term;
	logic [HASH_W-1:0] delta;
	logic [HASH_W-1:0] delta_s2;
	item_info_t        info_s2;
	logic              valid_s2;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_new;
	logic [31:0]       mask;
	logic              hit;

	// byte leaving the window is weighted by 3^(WINDOW+1)
	always_comb begin
		old_term = old_ok_s1 ? (HASH_W'(old_s1) * OUT_WEIGHT) : '0;
		delta    = (HASH_W'(byte_s1) + (HASH_W'(byte_s1) << 1)) - old_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		delta_s2 <= delta;
		info_s2  <= info_s1;
	end

	assign hash_new = (hash_q << 1) + hash_q + delta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (valid_s2) begin
			hash_q <= info_s2.fin ? '0 : hash_new;
		end
	end

	always_comb begin
		mask = (32'd1 << modulus_log2) - 32'd1;
		hit  = info_s2.elig && !info_s2.fin &&
		       ((hash_new[31:0] & mask) == {16'd0, target_value});
	end

	// results in order: start of buffer, hash boundary, length
	always_comb begin
		logic [1:0] n;
		n    = 2'd0;
		push = '0;
		if (valid_s2) begin
			if (info_s2.first) begin
				push.res[n] = '{pos: '0, last: 1'b0};
				n = n + 2'd1;
			end
			if (hit) begin
				push.res[n] = '{pos: info_s2.pos_hash, last: 1'b0};
				n = n + 2'd1;
			end
			if (info_s2.fin) begin
				push.res[n] = '{pos: info_s2.len, last: 1'b1};
				n = n + 2'd1;
			end
		end
		push.n = n;
	end

	a_fin_clears_hash: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && info_s2.fin |=> hash_q == '0)
		else $error("hash not cleared after last byte");

	a_no_test_on_fin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && info_s2.fin |-> !hit)
		else $error("hash boundary raised on last byte");

endmodule
`default_nettype wire

FILE: rtl/rhcb_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_outq
// Result queue: takes up to three results a cycle, gives one per transfer.
// ----------------------------------------------------------------------------
module rhcb_outq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rhcb_pkg::push_t                push,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output rhcb_pkg::res_t                      out_res,
	output logic [rhcb_pkg::OQ_CW-1:0]          level
);
	import rhcb_pkg::*;

	res_t             mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign out_res   = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign level     = count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.n) begin
				mem[wr_ptr_q + OQ_AW'(i)] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push.n);
			rd_ptr_q <= rd_ptr_q + OQ_AW'(pop);
			count_q  <= count_q + OQ_CW'(push.n) - OQ_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		OQ_CW'(count_q) + OQ_CW'(push.n) <= OQ_CW'(OQ_DEPTH))
		else $error("result queue overflow");

endmodule
`default_nettype wire

FILE: rtl/rolling_hash_chunk_boundary_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_hash_chunk_boundary_top
// Content-defined chunking: base-3 rolling hash over a byte window.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_axis: one byte per transfer, tlast on the last byte of a
//   buffer. Output stream m_axis: one boundary offset per transfer; tlast
//   marks the buffer length, the last result of a buffer. A buffer yields
//   offset 0, then any hash boundaries, then its length.
//   Config channel: cfg_index 0 = modulus_log2, 1 = target_value; always
//   ready, write only while the block is idle.
// Throughput: one byte per cycle unless s_axis_tready drops; the hash
//   recurrence is a single 64-bit three-input add in stage 2, the delay line
//   one RAM read and write a cycle. A byte passes the stage 1 and stage 2
//   registers; its results enter the result queue from stage 2, then show on m_axis.
// Stall: s_axis_tready drops while the result queue could not hold the
//   worst case (three results) of every byte in flight plus one more;
//   the queue holds 16 results, so a stalled receiver is absorbed for a
//   while and input carries on meanwhile.
// Reset: config and valid registers, hash and counters clear at once; the
//   delay-line RAM is not swept, a byte count masks entries older than the
//   current buffer, so the block takes input as soon as reset is released.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_boundary_top #(
	parameter int WINDOW   = 16,
	parameter int POS_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  wire logic                           s_axis_tlast,  // is_final
	// output stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [31:0]                         m_axis_tdata,  // [31:0] boundary_position
	output logic                                m_axis_tlast,  // run_end
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rhcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rhcb_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rhcb_pkg::*;

	localparam int WAW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int WIDE = (POS_BITS + 1 > RES_POS_W) ? POS_BITS + 1 : RES_POS_W;
	localparam logic [WIDE-1:0] POS_MAX = WIDE'((65'd1 << POS_BITS) - 65'd1);
	localparam logic [WAW-1:0]  WP_LAST = WAW'(WINDOW - 1);

	// config registers
	logic [MLOG_W-1:0]   modulus_log2_q;
	logic [TARGET_W-1:0] target_value_q;

	// stage 0 state
	logic [POS_BITS-1:0] byte_count_q;
	logic [WAW-1:0]      wp_q;

	// stage 1
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                old_ok_s1;
	item_info_t          info_s1;
	logic [BYTE_W-1:0]   old_s1;

	logic                accept;
	logic [WIDE-1:0]     p_w;
	logic [WIDE-1:0]     len_w;
	logic [WIDE-1:0]     len_sat;
	logic [WIDE-1:0]     hpos_w;
	logic [WIDE-1:0]     hpos_sat;
	item_info_t          info_s0;

	push_t               push;
	res_t                out_res;
	logic [OQ_CW-1:0]    level;
	logic [OQ_CW-1:0]    reserve;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_log2_q <= MLOG_RESET;
			target_value_q <= TARGET_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULUS_LOG2: modulus_log2_q <= cfg_data[MLOG_W-1:0];
				REG_TARGET_VALUE: target_value_q <= cfg_data[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	// room for the worst case of every byte in flight and the next one
	assign reserve       = OQ_CW'(MAX_RES) * (OQ_CW'(valid_s1) + OQ_CW'(push.n != 2'd0
	                       || 1'b0) + OQ_CW'(1));
	assign s_axis_tready = (OQ_CW'(OQ_DEPTH) - level) >= reserve;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// positions, saturating at the top of the counter range
	always_comb begin
		p_w      = WIDE'(byte_count_q);
		len_w    = p_w + WIDE'(1);
		len_sat  = (len_w > POS_MAX) ? POS_MAX : len_w;
		hpos_w   = p_w + WIDE'(2) - WIDE'(WINDOW);
		hpos_sat = (hpos_w > POS_MAX) ? POS_MAX : hpos_w;
		info_s0.first    = (byte_count_q == '0);
		info_s0.fin      = s_axis_tlast;
		info_s0.elig     = (p_w >= WIDE'(2 * WINDOW - 1));
		info_s0.pos_hash = hpos_sat[RES_POS_W-1:0];
		info_s0.len      = len_sat[RES_POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			wp_q         <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (s_axis_tlast) begin
					byte_count_q <= '0;
					wp_q         <= '0;
				end else begin
					byte_count_q <= len_sat[POS_BITS-1:0];
					wp_q         <= (wp_q == WP_LAST) ? '0 : wp_q + WAW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_s1   <= s_axis_tdata;
		info_s1   <= info_s0;
		old_ok_s1 <= (p_w >= WIDE'(WINDOW));
	end

	// delay line: the slot read is the one written WINDOW bytes earlier
	rhcb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW),
		.AW    (WAW)
	) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (s_axis_tdata),
		.re    (accept),
		.raddr (wp_q),
		.rdata (old_s1)
	);

	rhcb_hash #(
		.WINDOW (WINDOW)
	) u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.byte_s1      (byte_s1),
		.old_s1       (old_s1),
		.old_ok_s1    (old_ok_s1),
		.info_s1      (info_s1),
		.modulus_log2 (modulus_log2_q),
		.target_value (target_value_q),
		.push         (push)
	);

	rhcb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.level     (level)
	);

	assign m_axis_tdata = out_res.pos;
	assign m_axis_tlast = out_res.last;

	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= WP_LAST)
		else $error("delay-line pointer out of range");

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=> byte_count_q == '0 && wp_q == '0)
		else $error("position not cleared after last byte");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> level <= OQ_CW'(OQ_DEPTH - MAX_RES))
		else $error("input taken without queue room");

endmodule
`default_nettype wire

FILE: sim/rhcb_boundary_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcb_boundary_checker
// Watches the byte, result and register channels of the chunker, predicts
// the boundary offsets of every accepted byte and checks each result against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rhcb_boundary_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  wire logic                           s_axis_tlast,  // is_final
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [31:0]                    m_axis_tdata,  // [31:0] boundary_position
	input  wire logic                           m_axis_tlast,  // run_end
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [rhcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rhcb_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                           end_of_test,
	output int                                  errors,
	output int                                  pending,
	output int                                  n_buffers,
	output int                                  n_results,
	output int                                  n_hash_hits
);

	import rhcb_pkg::*;

	localparam int          WINDOW      = 16;
	localparam logic [63:0] DROP_WEIGHT = 64'd129140163; // 3^(WINDOW+1)
	localparam int          PRINT_CAP   = 40;

	logic [MLOG_W-1:0]   mod_log2;
	logic [TARGET_W-1:0] target;
	logic [63:0]         hash_acc;
	logic [7:0]          win_q [WINDOW];
	logic [31:0]         byte_pos;
	logic                leftover_done;
	res_t                expected_bounds [$];

	task report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("%0t MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	// one byte of the buffer: roll the hash, shift the delay line, queue results
	task predict_byte(input logic [7:0] d, input logic fin);
		logic [31:0] p;
		logic [63:0] mask;
		res_t        r;
		p    = byte_pos;
		mask = (64'd1 << mod_log2) - 64'd1;
		hash_acc = hash_acc * 64'd3 - {56'd0, win_q[WINDOW-1]} * DROP_WEIGHT
			+ {56'd0, d} * 64'd3;
		for (int k = WINDOW - 1; k > 0; k--)
			win_q[k] = win_q[k-1];
		win_q[0] = d;

		if (p == 32'd0) begin
			r.pos  = 32'd0;
			r.last = 1'b0;
			expected_bounds = {expected_bounds, r};
		end
		if (!fin && p >= 32'(2 * WINDOW - 1) && (hash_acc & mask) == {48'd0, target}) begin
			r.pos  = p - 32'(WINDOW) + 32'd2;
			r.last = 1'b0;
			expected_bounds = {expected_bounds, r};
			n_hash_hits++;
		end
		if (fin) begin
			r.pos  = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
			r.last = 1'b1;
			expected_bounds = {expected_bounds, r};
			hash_acc = 64'd0;
			for (int k = 0; k < WINDOW; k++)
				win_q[k] = 8'd0;
			byte_pos = 32'd0;
			n_buffers++;
		end else begin
			byte_pos = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mod_log2      = MLOG_RESET;
			target        = TARGET_RESET;
			hash_acc      = 64'd0;
			byte_pos      = 32'd0;
			for (int k = 0; k < WINDOW; k++)
				win_q[k] = 8'd0;
			expected_bounds.delete();
			errors        = 0;
			pending       = 0;
			n_buffers     = 0;
			n_results     = 0;
			n_hash_hits   = 0;
			leftover_done = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS_LOG2: mod_log2 = cfg_data[MLOG_W-1:0];
					REG_TARGET_VALUE: target   = cfg_data[TARGET_W-1:0];
					default: ;
				endcase
			end
			// input first: a result never shows in the cycle of its own byte
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (expected_bounds.size() == 0) begin
					report_mismatch($sformatf("unexpected result pos=%0d last=%0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_bounds.pop_front();
					if (m_axis_tdata !== want.pos)
						report_mismatch($sformatf("boundary_position got %0d want %0d",
							m_axis_tdata, want.pos));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("run_end got %0b want %0b at pos %0d",
							m_axis_tlast, want.last, want.pos));
				end
			end
			if (end_of_test && !leftover_done) begin
				leftover_done = 1'b1;
				if (expected_bounds.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						expected_bounds.size()));
			end
			pending = expected_bounds.size();
		end
	end

endmodule

FILE: sim/rolling_hash_chunk_boundary_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_chunk_boundary_top_tb
// Drives byte buffers into the chunker under a series of modulus and target
// settings, with random gaps on the input and random back-pressure on the
// output; a separate checker predicts and compares every boundary offset.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_boundary_top_tb;

	import rhcb_pkg::*;

	localparam int PHASE_BYTES   = 1;      // least random bytes per register setting
	localparam int SETTLE_CYCLES = 8;      // pipeline depth plus margin
	localparam int CYCLE_LIMIT   = 300000; // far beyond the slowest legal run
	localparam int N_PHASES      = 10;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = 8'd0; // [7:0] data_byte
	logic                 s_axis_tlast  = 1'b0; // is_final
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;         // [31:0] boundary_position
	logic                 m_axis_tlast;         // run_end
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = REG_MODULUS_LOG2;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;
	logic                 end_of_test   = 1'b0;

	int errors, pending, n_buffers, n_results, n_hash_hits;
	int cycle_count = 0;
	int sent_bytes  = 0;
	int settings    = 0;
	bit tx_steady   = 1'b0; // sender runs without gaps while set
	bit rx_steady   = 1'b0; // receiver never stalls while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rolling_hash_chunk_boundary_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rhcb_boundary_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.end_of_test   (end_of_test),
		.errors        (errors),
		.pending       (pending),
		.n_buffers     (n_buffers),
		.n_results     (n_results),
		.n_hash_hits   (n_hash_hits)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			cycle_count++;
		end
	end

	// receiver: may stall before each transfer, with stretches of no stalling
	// at all; tready only changes on the falling edge
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(19, 0) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(13, 0);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Called at a falling edge, returns at a falling edge. tvalid stays high
	// between back-to-back bytes, so it gets one assignment per step at most.
	task automatic send_byte(input logic [7:0] d, input logic fin);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent_bytes++;
	endtask

	// pattern: 0 random, 1 one repeated byte, 2 all ones, 3 mix of 00/FF
	task automatic send_buffer(input int len, input int pattern);
		logic [7:0] fill;
		logic [7:0] d;
		fill = 8'($urandom);
		for (int i = 0; i < len; i++) begin
			case (pattern)
				1:       d = fill;
				2:       d = 8'hFF;
				3:       d = $urandom_range(1, 0) ? 8'hFF : 8'h00;
				default: d = 8'($urandom);
			endcase
			send_byte(d, i == len - 1);
		end
	endtask

	// sender holds off until every predicted result has come out, then lets
	// bytes that produce no result clear the pipeline
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// writes both registers back to back; only legal while the block is idle
	task automatic write_settings(input logic [MLOG_W-1:0] mlog,
			input logic [TARGET_W-1:0] tgt);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MODULUS_LOG2;
		cfg_data  <= CFG_DAT_W'(mlog);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_TARGET_VALUE;
		cfg_data  <= tgt;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin : stimulus
		logic [MLOG_W-1:0]   mlog_tab [N_PHASES];
		logic [TARGET_W-1:0] tgt_tab  [N_PHASES];
		int                  phase_start;
		int                  len;

		// Settings run from the widest match (modulus 1, every eligible byte
		// hits) to no match at all (target at or above the modulus), and up
		// to a 31-bit mask past the nominal range.
		mlog_tab[0] = 5'd0;  tgt_tab[0] = 16'd0;
		mlog_tab[1] = 5'd16; tgt_tab[1] = 16'($urandom);
		mlog_tab[2] = 5'd1;  tgt_tab[2] = 16'($urandom_range(1, 0));
		mlog_tab[3] = 5'd2;  tgt_tab[3] = 16'($urandom_range(3, 0));
		mlog_tab[4] = 5'd31; tgt_tab[4] = 16'hFFFF;
		mlog_tab[5] = 5'd4;  tgt_tab[5] = 16'($urandom_range(65535, 16));
		mlog_tab[6] = 5'd3;  tgt_tab[6] = 16'($urandom_range(7, 0));
		mlog_tab[7] = 5'd0;  tgt_tab[7] = 16'hFFFF;
		mlog_tab[8] = 5'd8;  tgt_tab[8] = 16'($urandom_range(255, 0));
		mlog_tab[9] = 5'd5;  tgt_tab[9] = 16'($urandom_range(31, 0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset settings: one-byte buffers at both
		// byte extremes, then a buffer too short for any hash boundary
		send_buffer(1, 2);
		send_byte(8'h00, 1'b1);
		for (int i = 0; i < 20; i++)
			send_byte((i % 2) ? 8'hFF : 8'h00, i == 19);
		wait_idle();

		// random part: whole buffers, mostly long enough to reach the hash
		// test, some short ones; occasional full pauses mid-setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_settings(mlog_tab[ph], tgt_tab[ph]);
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES) begin
				tx_steady = ($urandom_range(3, 0) == 0);
				len = ($urandom_range(4, 0) == 0) ? $urandom_range(32, 1)
					: $urandom_range(60, 33);
				send_buffer(len, $urandom_range(3, 0));
				if ($urandom_range(5, 0) == 0)
					wait_idle();
			end
			wait_idle();
		end

		// drain, then let the checker flag anything still outstanding
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Covered %0d bytes in %0d buffers over %0d register settings plus reset.",
			sent_bytes, n_buffers, settings);
		$display("Checked %0d results, %0d of them hash boundaries; %0d mismatches.",
			n_results, n_hash_hits, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
